// ----- sv/gpd_pkg.sv -----
// Package: shared types, constants and helper functions for the pyramid downsampler.
`timescale 1ns / 1ps
package gpd_pkg;

  localparam int MaxWidth    = 2048;
  localparam int MaxHeight   = 4096;
  localparam int MaxChannels = 3;
  localparam int NumLines    = 4;
  localparam int AddrW       = $clog2(MaxWidth);

  // configuration register indexes
  localparam logic [1:0] CfgGrayMode    = 2'd0;
  localparam logic [1:0] CfgImageWidth  = 2'd1;
  localparam logic [1:0] CfgImageHeight = 2'd2;

  // horizontal tap source: 0 = current column sum, 1..4 = window cell, else zero
  localparam logic [2:0] HSrcZero = 3'd5;

  typedef logic [MaxChannels-1:0][7:0]  pix_t;
  typedef logic [MaxChannels-1:0][11:0] vsum_t;
  typedef logic [NumLines-1:0][MaxChannels*8-1:0] lines_t;

  typedef struct packed {
    logic [7:0] sample_c0;
    logic [7:0] sample_c1;
    logic [7:0] sample_c2;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_c0;
    logic [7:0]  out_c1;
    logic [7:0]  out_c2;
    logic [10:0] out_row;
    logic [9:0]  out_col;
    logic        frame_last;
  } out_t;

  function automatic logic [2:0] tap_weight(input int d);
    logic [2:0] w;
    begin
      unique case (d)
        0, 4:    w = 3'd1;
        1, 3:    w = 3'd4;
        default: w = 3'd6;
      endcase
      return w;
    end
  endfunction

  // mirror-101 reflection of index i into 0..n-1
  function automatic logic [12:0] mirror(input logic signed [14:0] i, input logic [12:0] n);
    logic signed [14:0] m;
    begin
      if (i < 15'sd0) begin
        m = -i;
      end else if (i >= $signed({2'b0, n})) begin
        m = $signed({1'b0, n, 1'b0}) - 15'sd2 - i;
      end else begin
        m = i;
      end
      return m[12:0];
    end
  endfunction

endpackage

// ----- sv/gpd_linebuf.sv -----
// Four source line buffers, one write slot and four registered reads per cycle.
`timescale 1ns / 1ps
module gpd_linebuf (
  input  logic                    clk_i,
  input  logic                    rd_en_i,
  input  logic [gpd_pkg::AddrW-1:0] addr_i,
  input  logic                    we_i,
  input  logic [1:0]              wslot_i,
  input  gpd_pkg::pix_t           wdata_i,
  output gpd_pkg::lines_t         rd_data_o
);

  for (genvar l = 0; l < gpd_pkg::NumLines; l++) begin : g_line
    logic [gpd_pkg::MaxChannels*8-1:0] mem [gpd_pkg::MaxWidth];
    logic [gpd_pkg::MaxChannels*8-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (we_i && (wslot_i == 2'(l))) begin
        mem[addr_i] <= wdata_i;
      end
    end

    // read-first: a same-cycle write to this slot is not seen
    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_q <= mem[addr_i];
      end
    end

    assign rd_data_o[l] = rd_q;
  end

endmodule

// ----- sv/gpd_cell.sv -----
// One cell of the column-sum window chain: holds a vertical sum, passes it on.
`timescale 1ns / 1ps
module gpd_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  gpd_pkg::vsum_t d_i,
  output gpd_pkg::vsum_t q_o
);

  gpd_pkg::vsum_t sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (shift_i) begin
      sum_q <= d_i;
    end
  end

  assign q_o = sum_q;

endmodule

// ----- sv/gaussian_pyramid_downsample.sv -----
// Top level: 5x5 binomial Gaussian pyramid downsampler, factor two.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one source pixel per
//   request in raster order; frame_start restarts the frame at (0,0).
//   Output channel (out_valid_o/out_ready_i/out_data_o) gives one filtered
//   pixel with its output row/column; frame_last flags the frame's last one.
//   Config port (cfg_we_i/cfg_idx_i/cfg_data_i) writes gray_mode, image_width
//   and image_height; write only while the block is idle.
// Timing:
//   One request per clock while no stall freezes the pipeline. A result
//   passes from the request that completes its 5x5 window through the
//   line-buffer read, vertical 1-4-6-4-1 sum, horizontal sum through the
//   window cell chain and the output register, in that order.
//   Rate is set by the single-port-per-slot line buffers, each read once per
//   request, with one of them written per request.
// Reset: counters, window cells and valids clear; registers go to RGB,
//   640 x 480. Line buffers are not cleared (every entry is written before use).
// Stall: when the output register holds an unaccepted result and another
//   result is ready to leave the last stage, the pipeline freezes and
//   in_ready_o drops; non-producing requests keep flowing.
module gaussian_pyramid_downsample (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gpd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gpd_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [12:0]   cfg_data_i
);

  // configuration
  logic        gray_q;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [11:0] wc;
  logic [12:0] hc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_q   <= 1'b0;
      width_q  <= 12'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gpd_pkg::CfgGrayMode:    gray_q   <= cfg_data_i[0];
        gpd_pkg::CfgImageWidth:  width_q  <= cfg_data_i[11:0];
        gpd_pkg::CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < 12'd4) begin
      wc = 12'd4;
    end else if (width_q > 12'(gpd_pkg::MaxWidth)) begin
      wc = 12'(gpd_pkg::MaxWidth);
    end else begin
      wc = width_q;
    end
    if (height_q < 13'd4) begin
      hc = 13'd4;
    end else if (height_q > 13'(gpd_pkg::MaxHeight)) begin
      hc = 13'(gpd_pkg::MaxHeight);
    end else begin
      hc = height_q;
    end
  end

  // pipeline control
  logic en;
  logic accept;
  logic s1_v_q, s2_v_q;
  logic s2_row_q, s2_col_q;

  assign en         = !out_valid_o || out_ready_i || !(s2_v_q && s2_row_q && s2_col_q);
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // stage 0: position, emit decision, tap sources
  logic [11:0] row_cnt_q;
  logic [10:0] col_cnt_q;
  logic        restart;
  logic [11:0] r;
  logic [10:0] c;
  gpd_pkg::pix_t pix;
  logic        ey, ex;
  logic [10:0] y;
  logic [10:0] x;
  logic [4:0][2:0] vsel;
  logic [4:0][2:0] hsel;
  logic        last;
  logic [12:0] kv, kh;
  logic signed [14:0] back;

  always_comb begin
    restart = in_data_i.frame_start || ({1'b0, row_cnt_q} >= hc) || ({1'b0, col_cnt_q} >= wc);
    r = restart ? 12'd0 : row_cnt_q;
    c = restart ? 11'd0 : col_cnt_q;
    pix[0] = in_data_i.sample_c0;
    pix[1] = gray_q ? 8'd0 : in_data_i.sample_c1;
    pix[2] = gray_q ? 8'd0 : in_data_i.sample_c2;

    ey = (!r[0] && (r >= 12'd2)) || (({1'b0, r} == hc - 13'd1) && !hc[0]);
    y  = r[0] ? r[11:1] : r[11:1] - 11'd1;
    ex = (!c[0] && (c >= 11'd2)) || (({1'b0, c} == {1'b0, wc} - 13'd1) && !wc[0]);
    x  = c[0] ? {1'b0, c[10:1]} : {1'b0, c[10:1]} - 11'd1;
    last = ({2'b0, y} == (hc >> 1) - 13'd1) && ({2'b0, x} == {1'b0, wc >> 1} - 13'd1);

    for (int d = 0; d < 5; d++) begin
      kv = gpd_pkg::mirror($signed({3'b0, y, 1'b0}) + $signed(15'(d)) - 15'sd2, hc);
      vsel[d] = (kv == {1'b0, r}) ? 3'b100 : {1'b0, kv[1:0]};
      kh = gpd_pkg::mirror($signed({3'b0, x, 1'b0}) + $signed(15'(d)) - 15'sd2, {1'b0, wc});
      back = $signed({4'b0, c}) - $signed({2'b0, kh});
      hsel[d] = (back >= 15'sd0 && back <= 15'sd4) ? back[2:0] : gpd_pkg::HSrcZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (accept) begin
      if ({2'b0, c} + 13'd1 >= {1'b0, wc}) begin
        col_cnt_q <= '0;
        row_cnt_q <= ({1'b0, r} + 13'd1 >= hc) ? 12'd0 : r + 12'd1;
      end else begin
        col_cnt_q <= c + 11'd1;
        row_cnt_q <= r;
      end
    end
  end

  gpd_pkg::lines_t rd_data;

  gpd_linebuf u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .addr_i    (c),
    .we_i      (accept),
    .wslot_i   (r[1:0]),
    .wdata_i   (pix),
    .rd_data_o (rd_data)
  );

  // stage 1 registers
  gpd_pkg::pix_t s1_pix_q;
  logic [4:0][2:0] s1_vsel_q, s1_hsel_q;
  logic s1_row_q, s1_col_q, s1_last_q;
  logic [10:0] s1_y_q;
  logic [9:0]  s1_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix;
      s1_vsel_q <= vsel;
      s1_hsel_q <= hsel;
      s1_row_q  <= ey;
      s1_col_q  <= ex;
      s1_last_q <= last;
      s1_y_q    <= y;
      s1_x_q    <= x[9:0];
    end
  end

  // stage 1: vertical sum
  gpd_pkg::vsum_t vsum;
  logic [7:0] vtap;

  always_comb begin
    for (int ch = 0; ch < gpd_pkg::MaxChannels; ch++) begin
      vsum[ch] = '0;
      for (int d = 0; d < 5; d++) begin
        vtap = s1_vsel_q[d][2] ? s1_pix_q[ch] : rd_data[s1_vsel_q[d][1:0]][ch*8 +: 8];
        vsum[ch] = vsum[ch] + 12'(gpd_pkg::tap_weight(d)) * {4'b0, vtap};
      end
    end
  end

  // stage 2 registers
  gpd_pkg::vsum_t s2_vsum_q;
  logic [4:0][2:0] s2_hsel_q;
  logic s2_last_q;
  logic [10:0] s2_y_q;
  logic [9:0]  s2_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_v_q) begin
      s2_vsum_q <= vsum;
      s2_hsel_q <= s1_hsel_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
      s2_y_q    <= s1_y_q;
      s2_x_q    <= s1_x_q;
    end
  end

  // window cell chain, cell 0 holds the most recent column sum
  gpd_pkg::vsum_t win [gpd_pkg::NumLines];
  logic shift;

  assign shift = en && s2_v_q && s2_row_q;

  for (genvar i = 0; i < gpd_pkg::NumLines; i++) begin : g_cell
    gpd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     ((i == 0) ? s2_vsum_q : win[(i == 0) ? 0 : i-1]),
      .q_o     (win[i])
    );
  end

  // stage 2: horizontal sum, rounding, saturation
  logic [15:0] hsum [gpd_pkg::MaxChannels];
  logic [11:0] htap;
  logic [16:0] rnd;
  gpd_pkg::pix_t res;

  always_comb begin
    for (int ch = 0; ch < gpd_pkg::MaxChannels; ch++) begin
      hsum[ch] = '0;
      for (int d = 0; d < 5; d++) begin
        unique case (s2_hsel_q[d])
          3'd0:    htap = s2_vsum_q[ch];
          3'd1:    htap = win[0][ch];
          3'd2:    htap = win[1][ch];
          3'd3:    htap = win[2][ch];
          3'd4:    htap = win[3][ch];
          default: htap = '0;
        endcase
        hsum[ch] = hsum[ch] + 16'(gpd_pkg::tap_weight(d)) * {4'b0, htap};
      end
      rnd = {1'b0, hsum[ch]} + 17'd128;
      res[ch] = (rnd[16:8] > 9'd255) ? 8'd255 : rnd[15:8];
    end
  end

  // output register
  logic out_valid_q;
  gpd_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && s2_v_q && s2_row_q && s2_col_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_v_q && s2_row_q && s2_col_q) begin
      out_q.out_c0     <= res[0];
      out_q.out_c1     <= res[1];
      out_q.out_c2     <= res[2];
      out_q.out_row    <= s2_y_q;
      out_q.out_col    <= s2_x_q;
      out_q.frame_last <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_last) |->
      ({3'b0, out_data_o.out_col} == {1'b0, wc >> 1} - 13'd1))
    else $error("frame_last on a column other than the last");

  a_window_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_v_q && s2_row_q) |=> (win[0] == $past(s2_vsum_q)))
    else $error("window cell did not take the column sum");
`endif

endmodule
